>>> src/jhs_pkg.sv
// Shared constants, types and helpers for the Jacobi heat stencil sweep unit.
package jhs_pkg;

    localparam int GRID_MAX_DEF = 1024;
    localparam int TEMP_W       = 16;
    localparam int IDX_W        = 10;
    localparam int RES_W        = 56;
    localparam int GS_W         = 11;
    localparam int CFG_W        = 56;
    localparam int CFG_IDX_W    = 1;
    localparam int SQ_W         = 2 * TEMP_W;

    localparam int GRID_SIZE_RESET = 16;
    localparam logic [RES_W-1:0] RES_LIMIT_RESET = RES_W'(262144);
    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RESIDUAL_LIMIT = CFG_IDX_W'(1);

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } cell_tag_t;

    // grid edge clamped to 3..gmax
    function automatic logic [31:0] eff_size(input logic [31:0] gs, input logic [31:0] gmax);
        logic [31:0] n;
        n = gs;
        if (n < 32'd3) begin
            n = 32'd3;
        end
        if (n > gmax) begin
            n = gmax;
        end
        return n;
    endfunction

endpackage

>>> src/jhs_line_buf.sv
// Two row line buffers and the neighbour window around the incoming cell.
module jhs_line_buf #(
    parameter int GRID_MAX = jhs_pkg::GRID_MAX_DEF,
    parameter int CNT_W    = $clog2(GRID_MAX)
) (
    input  logic                      aclk,
    input  logic                      shift_en,
    input  logic [CNT_W-1:0]          col,
    input  logic [CNT_W-1:0]          col_nxt,
    input  logic [jhs_pkg::TEMP_W-1:0] cell_temp,
    output logic [jhs_pkg::TEMP_W-1:0] up_q,
    output logic [jhs_pkg::TEMP_W-1:0] right_q,
    output logic [jhs_pkg::TEMP_W-1:0] cen_q,
    output logic [jhs_pkg::TEMP_W-1:0] left_q
);
    import jhs_pkg::*;

    logic [TEMP_W-1:0] upper_mem [GRID_MAX];
    logic [TEMP_W-1:0] mid_mem   [GRID_MAX];

    logic [TEMP_W-1:0] up_reg;
    logic [TEMP_W-1:0] right_reg;
    logic [TEMP_W-1:0] cen_reg;
    logic [TEMP_W-1:0] left_reg;

    // right_reg holds mid[col] until this beat: it is the centre of the cell
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            upper_mem[col] <= right_reg;
            mid_mem[col]   <= cell_temp;
            up_reg         <= upper_mem[col];
            right_reg      <= mid_mem[col_nxt];
            cen_reg        <= right_reg;
            left_reg       <= cen_reg;
        end
    end

    assign up_q    = up_reg;
    assign right_q = right_reg;
    assign cen_q   = cen_reg;
    assign left_q  = left_reg;

endmodule

>>> src/jacobi_heat_stencil_sweep_unit.sv
// Top level of the Jacobi five-point heat stencil sweep unit.
//
// Cells of a square grid enter on the s_ channel in raster order, one beat per
// cell, boundary included. For each interior cell the m_ channel returns the
// truncated four-neighbour average with its row and column, the running
// saturating residual, and on the last interior cell of a sweep the
// sweep_last and converged flags. Boundary cells give no result.
// The result for cell (r, c) comes out after cell (r+1, c) is taken, through
// three register stages (input/line-buffer, multiply, residual accumulate).
// One beat per cycle is sustained while m_ready stays high; the line
// buffers do one read and one write per row buffer per beat.
// When m_ready is low the pipeline fills and s_ready drops once every stage
// holds a result; nothing is lost or repeated.
// Reset clears the counters, residual and valid flags; grid size returns to
// 16 and the limit to 4.0. Line buffer contents are undefined until written.
// Writing grid_size restarts the sweep; write it only while the unit is idle.
module jacobi_heat_stencil_sweep_unit #(
    parameter int GRID_MAX = jhs_pkg::GRID_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [jhs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jhs_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jhs_pkg::TEMP_W-1:0]    s_cell_temp,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [jhs_pkg::TEMP_W-1:0]    m_new_temp,
    output logic [jhs_pkg::IDX_W-1:0]     m_row_index,
    output logic [jhs_pkg::IDX_W-1:0]     m_col_index,
    output logic                          m_sweep_last,
    output logic [jhs_pkg::RES_W-1:0]     m_residual,
    output logic                          m_converged
);
    import jhs_pkg::*;

    localparam int CNT_W = $clog2(GRID_MAX);
    localparam logic [31:0] RESET_N = eff_size(32'(GRID_SIZE_RESET), 32'(GRID_MAX));

    logic [CNT_W-1:0] n_m1_reg, n_m2_reg;
    logic [RES_W-1:0] limit_reg;
    logic [CNT_W-1:0] row_reg, col_reg;
    logic [RES_W-1:0] acc_reg;

    logic             s1_valid_reg, s2_valid_reg, m_valid_reg;
    cell_tag_t        s1_tag_reg, s2_tag_reg;
    logic [TEMP_W-1:0] s1_temp_reg;
    logic [TEMP_W-1:0] s2_nv_reg;
    logic [SQ_W-1:0]   s2_sq_reg;

    logic [TEMP_W-1:0] m_new_temp_reg;
    cell_tag_t         m_tag_reg;
    logic [RES_W-1:0]  m_residual_reg;
    logic              m_converged_reg;

    logic out_ok, s2_ok, s1_ok, accept;
    logic col_wrap, row_wrap, interior, is_last;
    logic [CNT_W-1:0] col_next, row_next;
    cell_tag_t tag_next;
    logic [31:0] n_wr;

    logic [TEMP_W-1:0] up_q, right_q, cen_q, left_q;
    logic [TEMP_W+1:0] nb_sum;
    logic [TEMP_W-1:0] nv, diff;
    logic [SQ_W-1:0]   sq;
    logic [RES_W:0]    acc_sum;
    logic [RES_W-1:0]  acc_sat;

    assign out_ok  = !m_valid_reg || m_ready;
    assign s2_ok   = !s2_valid_reg || out_ok;
    assign s1_ok   = !s1_valid_reg || s2_ok;
    assign s_ready = s1_ok;
    assign accept  = s_valid && s1_ok;

    assign col_wrap = (col_reg == n_m1_reg);
    assign row_wrap = (row_reg == n_m1_reg);
    assign col_next = col_wrap ? '0 : col_reg + CNT_W'(1);
    assign row_next = col_wrap ? (row_wrap ? '0 : row_reg + CNT_W'(1)) : row_reg;
    assign interior = (32'(row_reg) >= 32'd2) && (col_reg != '0) && (col_reg <= n_m2_reg);
    assign is_last  = row_wrap && (col_reg == n_m2_reg);

    assign tag_next.last = is_last;
    assign tag_next.row  = IDX_W'(32'(row_reg) - 32'd1);
    assign tag_next.col  = IDX_W'(32'(col_reg));

    assign n_wr = eff_size(32'(cfg_wdata[GS_W-1:0]), 32'(GRID_MAX));

    jhs_line_buf #(
        .GRID_MAX (GRID_MAX),
        .CNT_W    (CNT_W)
    ) u_line_buf (
        .aclk      (aclk),
        .shift_en  (accept),
        .col       (col_reg),
        .col_nxt   (col_next),
        .cell_temp (s_cell_temp),
        .up_q      (up_q),
        .right_q   (right_q),
        .cen_q     (cen_q),
        .left_q    (left_q)
    );

    assign nb_sum = (TEMP_W+2)'(up_q) + (TEMP_W+2)'(left_q)
                  + (TEMP_W+2)'(right_q) + (TEMP_W+2)'(s1_temp_reg);
    assign nv     = nb_sum[TEMP_W+1:2];
    assign diff   = (nv >= cen_q) ? nv - cen_q : cen_q - nv;
    assign sq     = SQ_W'(diff) * SQ_W'(diff);

    assign acc_sum = (RES_W+1)'(acc_reg) + (RES_W+1)'(s2_sq_reg);
    assign acc_sat = acc_sum[RES_W] ? RES_MAX : acc_sum[RES_W-1:0];

    // config, counters, valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_m1_reg     <= CNT_W'(RESET_N - 32'd1);
            n_m2_reg     <= CNT_W'(RESET_N - 32'd2);
            limit_reg    <= RES_LIMIT_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == REG_GRID_SIZE) begin
                n_m1_reg <= CNT_W'(n_wr - 32'd1);
                n_m2_reg <= CNT_W'(n_wr - 32'd2);
                row_reg  <= '0;
                col_reg  <= '0;
                acc_reg  <= '0;
            end else begin
                if (cfg_we && cfg_index == REG_RESIDUAL_LIMIT) begin
                    limit_reg <= cfg_wdata[RES_W-1:0];
                end
                if (accept) begin
                    row_reg <= row_next;
                    col_reg <= col_next;
                end
                if (out_ok && s2_valid_reg) begin
                    acc_reg <= s2_tag_reg.last ? '0 : acc_sat;
                end
            end

            if (accept) begin
                s1_valid_reg <= interior;
            end else if (s2_ok) begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_ok) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ok) begin
                m_valid_reg <= s2_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_tag_reg  <= tag_next;
            s1_temp_reg <= s_cell_temp;
        end
        if (s2_ok && s1_valid_reg) begin
            s2_tag_reg <= s1_tag_reg;
            s2_nv_reg  <= nv;
            s2_sq_reg  <= sq;
        end
        if (out_ok && s2_valid_reg) begin
            m_tag_reg       <= s2_tag_reg;
            m_new_temp_reg  <= s2_nv_reg;
            m_residual_reg  <= acc_sat;
            m_converged_reg <= s2_tag_reg.last && (acc_sat < limit_reg);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_new_temp   = m_new_temp_reg;
    assign m_row_index  = m_tag_reg.row;
    assign m_col_index  = m_tag_reg.col;
    assign m_sweep_last = m_tag_reg.last;
    assign m_residual   = m_residual_reg;
    assign m_converged  = m_converged_reg;

endmodule

>>> dv/jacobi_heat_stencil_sweep_unit_tb.sv
// Self-checking testbench for the Jacobi heat stencil sweep unit: directed table, then random sweeps.
`timescale 1ns / 100ps

module jacobi_heat_stencil_sweep_unit_tb;

    import jhs_pkg::*;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic [RES_W-1:0]  res;
        logic              conv;
    } stencil_out_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] sel;
        logic [CFG_W-1:0]     data;
        logic                 typed;
        stencil_out_t         want;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [TEMP_W-1:0]    s_cell_temp = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic [TEMP_W-1:0]    m_new_temp;
    logic [IDX_W-1:0]     m_row_index;
    logic [IDX_W-1:0]     m_col_index;
    logic                 m_sweep_last;
    logic [RES_W-1:0]     m_residual;
    logic                 m_converged;

    jacobi_heat_stencil_sweep_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cell_temp (s_cell_temp),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_temp  (m_new_temp),
        .m_row_index (m_row_index),
        .m_col_index (m_col_index),
        .m_sweep_last(m_sweep_last),
        .m_residual  (m_residual),
        .m_converged (m_converged)
    );

    // predictor state
    logic [GS_W-1:0]   grid_raw = GS_W'(GRID_SIZE_RESET);
    logic [RES_W-1:0]  res_limit = RES_LIMIT_RESET;
    logic [TEMP_W-1:0] up_row  [GRID_MAX_DEF];
    logic [TEMP_W-1:0] mid_row [GRID_MAX_DEF];
    int unsigned       row_n = 0;
    int unsigned       col_n = 0;
    logic [RES_W-1:0]  res_acc = '0;
    logic [TEMP_W-1:0] west_mid = '0;

    stencil_out_t pending_cells[$];
    int unsigned  cells_sent = 0;
    int unsigned  mismatches = 0;
    wire          steady = (cells_sent >= 400) && (cells_sent < 700);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("jacobi_heat_stencil_sweep_unit regression: fail");
        $finish;
    end

    function automatic bit sweep_cell(input logic [TEMP_W-1:0] x, output stencil_out_t o);
        int unsigned n, r, c, total, nv, ctr;
        logic [63:0] dlt, acc;
        bit          hit;
        n = (grid_raw < 3) ? 3 : ((grid_raw > GRID_MAX_DEF) ? GRID_MAX_DEF : grid_raw);
        hit = 1'b0;
        o = '0;
        if (col_n >= n) begin
            col_n = 0;
            row_n++;
        end
        if (row_n >= n) begin
            row_n = 0;
            res_acc = '0;
        end
        r = row_n;
        c = col_n;
        ctr = mid_row[c];
        if (r >= 2 && c >= 1 && c <= n - 2) begin
            total = up_row[c] + west_mid + mid_row[c+1] + x;
            nv = total >> 2;
            dlt = (nv >= ctr) ? nv - ctr : ctr - nv;
            acc = {8'd0, res_acc} + dlt * dlt;
            if (acc > {8'd0, RES_MAX}) begin
                acc = {8'd0, RES_MAX};
            end
            res_acc = acc[RES_W-1:0];
            o.temp = nv[TEMP_W-1:0];
            o.row  = IDX_W'(r - 1);
            o.col  = IDX_W'(c);
            o.last = (r == n - 1) && (c == n - 2);
            o.res  = res_acc;
            o.conv = o.last && (res_acc < res_limit);
            if (o.last) begin
                res_acc = '0;
            end
            hit = 1'b1;
        end
        west_mid = ctr[TEMP_W-1:0];
        up_row[c] = ctr[TEMP_W-1:0];
        mid_row[c] = x;
        col_n++;
        if (col_n >= n) begin
            col_n = 0;
            row_n++;
            if (row_n >= n) begin
                row_n = 0;
                res_acc = '0;
            end
        end
        return hit;
    endfunction

    function automatic logic [RES_W-1:0] pick_limit();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return '0;
            1: return RES_MAX;
            default: return RES_W'(r >> $urandom_range(8, 63));
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == REG_GRID_SIZE) begin
            grid_raw = data[GS_W-1:0];
            row_n    = 0;
            col_n    = 0;
            res_acc  = '0;
            west_mid = '0;
        end else begin
            res_limit = data[RES_W-1:0];
        end
        @(posedge aclk);
    endtask

    task automatic send_beat(input logic [TEMP_W-1:0] t, input bit typed, input stencil_out_t want);
        stencil_out_t pred;
        bit           hit;
        if (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cell_temp <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cells_sent++;
        hit = sweep_cell(t, pred);
        if (typed) begin
            pending_cells.push_back(want);
        end else if (hit) begin
            pending_cells.push_back(pred);
        end
    endtask

    // drain: all results back, then let trailing boundary cells leave the pipe
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        stencil_out_t exp_cell;
        if (aresetn && m_valid && m_ready) begin
            if (pending_cells.size() == 0) begin
                mismatches++;
                $display("%0t ns: result beat with none expected, expected none got row %0d col %0d",
                         $time, m_row_index, m_col_index);
            end else begin
                exp_cell = pending_cells.pop_front();
                check_field("new_temp", exp_cell.temp, m_new_temp);
                check_field("row_index", exp_cell.row, m_row_index);
                check_field("col_index", exp_cell.col, m_col_index);
                check_field("sweep_last", exp_cell.last, m_sweep_last);
                check_field("residual", exp_cell.res, m_residual);
                check_field("converged", exp_cell.conv, m_converged);
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    initial begin
        plan_row_t         plan[$];
        plan_row_t         row;
        logic [CFG_W-1:0]  wdat;
        logic [GS_W-1:0]   gs;
        logic [TEMP_W-1:0] base, t;
        int unsigned       n, cells, mode, random_cells;
        bit                wide_done;

        random_cells = 0;
        wide_done = 1'b0;
        foreach (up_row[i]) begin
            up_row[i]  = '0;
            mid_row[i] = '0;
        end

        // 3x3 sweeps: flat hot grid, hot centre in cold grid, flat grid with zero limit
        row = '0;
        row.is_cfg = 1'b1;
        row.sel    = REG_GRID_SIZE;
        row.data   = 56'hAB_CDEF_0123_4800;
        plan.push_back(row);
        for (int b = 0; b < 3; b++) begin
            if (b == 2) begin
                row = '0;
                row.is_cfg = 1'b1;
                row.sel    = REG_RESIDUAL_LIMIT;
                plan.push_back(row);
            end
            for (int k = 0; k < 9; k++) begin
                row = '0;
                row.data  = (b == 1 && k != 4) ? 16'h0000 : 16'hFFFF;
                row.typed = (k == 7);
                if (k == 7) begin
                    row.want = (b == 1)
                        ? stencil_out_t'{16'h0000, 10'd1, 10'd1, 1'b1, 56'hFFFE0001, 1'b0}
                        : stencil_out_t'{16'hFFFF, 10'd1, 10'd1, 1'b1, 56'd0, b == 0};
                end
                plan.push_back(row);
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                cfg_write(plan[i].sel, plan[i].data);
            end else begin
                send_beat(plan[i].data[TEMP_W-1:0], plan[i].typed, plan[i].want);
            end
        end

        while (random_cells < 1300) begin
            settle();
            if (!wide_done && random_cells >= 650) begin
                // full-size or oversize grid: clamped edge, first row only
                wide_done = 1'b1;
                wdat = CFG_W'({$urandom, $urandom});
                wdat[GS_W-1:0] = $urandom_range(0, 1) ? 11'd1024 : 11'd2047;
                cfg_write(REG_GRID_SIZE, wdat);
                cfg_write(REG_RESIDUAL_LIMIT, pick_limit());
                repeat (40) begin
                    send_beat(16'($urandom), 1'b0, '0);
                    random_cells++;
                end
            end else begin
                case ($urandom_range(0, 19))
                    0: gs = GS_W'($urandom_range(0, 2));
                    1, 2, 3: gs = GS_W'($urandom_range(11, 24));
                    default: gs = GS_W'($urandom_range(3, 10));
                endcase
                wdat = CFG_W'({$urandom, $urandom});
                wdat[GS_W-1:0] = gs;
                cfg_write(REG_GRID_SIZE, wdat);
                if ($urandom_range(0, 9) < 7) begin
                    cfg_write(REG_RESIDUAL_LIMIT, pick_limit());
                end
                n = (gs < 3) ? 3 : gs;
                mode = $urandom_range(0, 3);
                base = 16'($urandom);
                cells = ((n > 10) ? 1 : $urandom_range(1, 3)) * n * n;
                if ($urandom_range(0, 2) == 0) begin
                    cells += $urandom_range(1, n * n - 1);
                end
                repeat (cells) begin
                    case (mode)
                        0: t = 16'($urandom);
                        1: t = base;
                        2: t = base + 16'($urandom_range(0, 15));
                        default: t = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    endcase
                    send_beat(t, 1'b0, '0);
                    random_cells++;
                end
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("jacobi_heat_stencil_sweep_unit regression: pass");
        end else begin
            $display("jacobi_heat_stencil_sweep_unit regression: fail");
        end
        $finish;
    end

endmodule
